// ===== hw/rtl/digital_clock_with_set_and_display_scan_macros.svh =====
// Assertion macros for the digital clock block.
// Taken in by the top level only; it depends on nothing else.
`ifndef DIGITAL_CLOCK_WITH_SET_AND_DISPLAY_SCAN_MACROS_SVH
`define DIGITAL_CLOCK_WITH_SET_AND_DISPLAY_SCAN_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DCLK_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DCLK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dclk_pkg.sv =====
// Types, constants and helper functions of the digital clock block.
// Used by digital_clock_with_set_and_display_scan; depends on nothing.
`default_nettype none

package dclk_pkg;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SCAN = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        DIGIT_HOUR_TENS  = 2'd0,
        DIGIT_HOUR_UNITS = 2'd1,
        DIGIT_MIN_TENS   = 2'd2,
        DIGIT_MIN_UNITS  = 2'd3
    } digit_t;

    typedef struct packed {
        cmd_t command;
        logic raw_hour_switch;
        logic raw_minute_switch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] anode_byte;
        logic [7:0] segment_byte;
        logic [4:0] hours_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic       time_is_set;
    } result_item_t;

    localparam logic [9:0] TICK_LIMIT_RESET = 10'd511;
    localparam logic [7:0] PRESS_PATTERN    = 8'h80;
    localparam logic [4:0] LAST_HOUR        = 5'd23;
    localparam logic [5:0] LAST_SIXTY       = 6'd59;

    function automatic logic [4:0] next_hour(input logic [4:0] h);
        return (h >= LAST_HOUR) ? 5'd0 : h + 5'd1;
    endfunction

    function automatic logic [5:0] next_sixty(input logic [5:0] v);
        return (v >= LAST_SIXTY) ? 6'd0 : v + 6'd1;
    endfunction

    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd60) begin
            t = 3'd6;
        end else if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [5:0] v);
        logic [5:0] r;
        r = v - 6'(tens_of(v)) * 6'd10;
        return r[3:0];
    endfunction

    function automatic logic [6:0] seg_of(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0: s = 7'h3f;
            4'd1: s = 7'h06;
            4'd2: s = 7'h5b;
            4'd3: s = 7'h4f;
            4'd4: s = 7'h66;
            4'd5: s = 7'h6d;
            4'd6: s = 7'h7d;
            4'd7: s = 7'h07;
            4'd8: s = 7'h7f;
            4'd9: s = 7'h6f;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/digital_clock_with_set_and_display_scan.sv =====
// Top level of the 24-hour clock with set buttons and a four-digit display scan.
// Depends on dclk_pkg and on digital_clock_with_set_and_display_scan_macros.svh.
//
// The block takes one request per clock cycle while the result side is ready, and returns
// one result per request. A request is held in an input register, the time, prescaler,
// debouncers and scan position are updated by one pass of short logic, and the result
// lands in an output register that lets the next request in while it waits to be taken.
// A tick request runs the prescaler and the debouncers; a scan request returns the anode
// and segment bytes of the next digit. The user must write the tick limit through the
// configuration channel only while no request is in flight; the block itself does not
// enforce this. The tick limit resets to 511.
`default_nettype none

`include "digital_clock_with_set_and_display_scan_macros.svh"

module digital_clock_with_set_and_display_scan
    import dclk_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [9:0]   cfg_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire in_item_t     s_item,
    output logic              m_valid,
    input  wire logic         m_ready,
    output result_item_t      m_item
);

    logic         in_vld_reg;
    in_item_t     in_reg;
    logic         out_vld_reg;
    result_item_t out_reg;
    result_item_t out_next;
    logic         fire;

    logic [9:0] tick_limit_reg;
    logic [9:0] prescale_reg, prescale_next;
    logic [4:0] hours_reg, hours_next;
    logic [5:0] minutes_reg, minutes_next;
    logic [5:0] seconds_reg, seconds_next;
    logic       set_reg, set_next;
    logic [7:0] hour_db_reg, hour_db_next;
    logic [7:0] minute_db_reg, minute_db_next;
    digit_t     scan_reg, scan_next;

    logic       odd_second;
    logic [3:0] digit_value;
    logic [6:0] digit_segments;

    assign cfg_ready = 1'b1;
    assign fire      = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || fire;
    assign m_valid   = out_vld_reg;
    assign m_item    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            tick_limit_reg <= TICK_LIMIT_RESET;
            prescale_reg   <= '0;
            hours_reg      <= '0;
            minutes_reg    <= '0;
            seconds_reg    <= '0;
            set_reg        <= 1'b0;
            hour_db_reg    <= '1;
            minute_db_reg  <= '1;
            scan_reg       <= DIGIT_HOUR_TENS;
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (fire) begin
                in_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_valid) begin
                tick_limit_reg <= cfg_data;
            end
            prescale_reg  <= prescale_next;
            hours_reg     <= hours_next;
            minutes_reg   <= minutes_next;
            seconds_reg   <= seconds_next;
            set_reg       <= set_next;
            hour_db_reg   <= hour_db_next;
            minute_db_reg <= minute_db_next;
            scan_reg      <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign odd_second = seconds_reg[0];

    always_comb begin
        unique case (scan_reg)
            DIGIT_HOUR_TENS:  digit_value = {1'b0, tens_of({1'b0, hours_reg})};
            DIGIT_HOUR_UNITS: digit_value = units_of({1'b0, hours_reg});
            DIGIT_MIN_TENS:   digit_value = {1'b0, tens_of(minutes_reg)};
            DIGIT_MIN_UNITS:  digit_value = units_of(minutes_reg);
            default:          digit_value = '0;
        endcase
        digit_segments = seg_of(digit_value);
    end

    always_comb begin
        prescale_next  = prescale_reg;
        hours_next     = hours_reg;
        minutes_next   = minutes_reg;
        seconds_next   = seconds_reg;
        set_next       = set_reg;
        hour_db_next   = hour_db_reg;
        minute_db_next = minute_db_reg;
        scan_next      = scan_reg;
        out_next       = '0;

        if (fire) begin
            unique case (in_reg.command)
                CMD_TICK: begin
                    if (prescale_reg > tick_limit_reg) begin
                        seconds_next = next_sixty(seconds_reg);
                        if (seconds_next == 6'd0) begin
                            minutes_next = next_sixty(minutes_reg);
                            if (minutes_next == 6'd0) begin
                                hours_next = next_hour(hours_reg);
                            end
                        end
                        prescale_next = 10'd1;
                    end else begin
                        prescale_next = prescale_reg + 10'd1;
                    end
                    hour_db_next   = {hour_db_reg[6:0], in_reg.raw_hour_switch};
                    minute_db_next = {minute_db_reg[6:0], in_reg.raw_minute_switch};
                    if (hour_db_next == PRESS_PATTERN) begin
                        hours_next = next_hour(hours_next);
                        set_next   = 1'b1;
                    end
                    if (minute_db_next == PRESS_PATTERN) begin
                        minutes_next = next_sixty(minutes_next);
                        seconds_next = 6'd0;
                        set_next     = 1'b1;
                    end
                end
                CMD_SCAN: begin
                    out_next.anode_byte = ~(8'd1 << scan_reg);
                    if (!set_reg && odd_second) begin
                        out_next.segment_byte = 8'h00;
                    end else begin
                        out_next.segment_byte =
                            {(scan_reg == DIGIT_HOUR_UNITS) && odd_second, digit_segments};
                    end
                    scan_next = digit_t'(scan_reg + 2'd1);
                end
                default: begin
                    out_next = '0;
                end
            endcase
        end

        out_next.hours_now   = hours_next;
        out_next.minutes_now = minutes_next;
        out_next.seconds_now = seconds_next;
        out_next.time_is_set = set_next;
    end

    `DCLK_ASSERT_NOW(a_time_in_range, aclk, aresetn, 1'b1, (hours_reg <= LAST_HOUR) && (minutes_reg <= LAST_SIXTY) && (seconds_reg <= LAST_SIXTY), "time of day left its range")
    `DCLK_ASSERT_NEXT(a_set_sticks, aclk, aresetn, set_reg, set_reg, "set flag was cleared")
    `DCLK_ASSERT_NEXT(a_tick_keeps_scan, aclk, aresetn, fire && (in_reg.command == CMD_TICK), $stable(scan_reg), "tick moved the scan position")
    `DCLK_ASSERT_NEXT(a_scan_keeps_time, aclk, aresetn, fire && (in_reg.command == CMD_SCAN), $stable(hours_reg) && $stable(minutes_reg) && $stable(seconds_reg), "scan changed the time")

endmodule

`default_nettype wire

// ===== tb/tb_digital_clock_with_set_and_display_scan.sv =====
// Self-checking testbench for the 24-hour clock with set buttons and display scan.
// Depends on dclk_pkg and the top level; a tracker class predicts every result and
// compares it with what the block returns, while plain tasks drive the requests.
`default_nettype none

module tb_digital_clock_with_set_and_display_scan;
    import dclk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class clock_tracker;
        logic [9:0]   limit;
        logic [9:0]   presc;
        logic [4:0]   hrs;
        logic [5:0]   mins;
        logic [5:0]   secs;
        logic         is_set;
        logic [7:0]   hour_db;
        logic [7:0]   min_db;
        digit_t       pos;
        result_item_t pending[$];
        int           errors;
        int           checked;

        function new();
            limit   = TICK_LIMIT_RESET;
            presc   = '0;
            hrs     = '0;
            mins    = '0;
            secs    = '0;
            is_set  = 1'b0;
            hour_db = 8'hff;
            min_db  = 8'hff;
            pos     = DIGIT_HOUR_TENS;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_limit(logic [9:0] v);
            limit = v;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function logic [5:0] wrap_sixty(logic [5:0] v);
            return (v >= 6'd59) ? 6'd0 : v + 6'd1;
        endfunction

        function logic [4:0] wrap_day(logic [4:0] v);
            return (v >= 5'd23) ? 5'd0 : v + 5'd1;
        endfunction

        function logic [7:0] glyph(int d);
            logic [7:0] g;
            case (d)
                0: g = 8'h3f;
                1: g = 8'h06;
                2: g = 8'h5b;
                3: g = 8'h4f;
                4: g = 8'h66;
                5: g = 8'h6d;
                6: g = 8'h7d;
                7: g = 8'h07;
                8: g = 8'h7f;
                9: g = 8'h6f;
                default: g = 8'h00;
            endcase
            return g;
        endfunction

        function void take_request(in_item_t it);
            result_item_t r;
            r = '0;
            if (it.command == CMD_TICK) begin
                if (presc > limit) begin
                    secs = wrap_sixty(secs);
                    if (secs == 6'd0) begin
                        mins = wrap_sixty(mins);
                        if (mins == 6'd0) begin
                            hrs = wrap_day(hrs);
                        end
                    end
                    presc = '0;
                end
                presc   = presc + 10'd1;
                hour_db = {hour_db[6:0], it.raw_hour_switch};
                min_db  = {min_db[6:0], it.raw_minute_switch};
                if (hour_db == 8'h80) begin
                    hrs    = wrap_day(hrs);
                    is_set = 1'b1;
                end
                if (min_db == 8'h80) begin
                    mins   = wrap_sixty(mins);
                    secs   = '0;
                    is_set = 1'b1;
                end
            end else begin
                case (pos)
                    DIGIT_HOUR_TENS: r.segment_byte = glyph(int'(hrs) / 10);
                    DIGIT_HOUR_UNITS: begin
                        r.segment_byte = glyph(int'(hrs) % 10);
                        if (secs[0]) begin
                            r.segment_byte[7] = 1'b1;
                        end
                    end
                    DIGIT_MIN_TENS: r.segment_byte = glyph(int'(mins) / 10);
                    default: r.segment_byte = glyph(int'(mins) % 10);
                endcase
                if (!is_set && secs[0]) begin
                    r.segment_byte = '0;
                end
                r.anode_byte = ~(8'd1 << pos);
                pos = digit_t'((int'(pos) + 1) % 4);
            end
            r.hours_now   = hrs;
            r.minutes_now = mins;
            r.seconds_now = secs;
            r.time_is_set = is_set;
            pending.push_back(r);
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
        endfunction

        function void compare_result(result_item_t got);
            result_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: result %0h arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.anode_byte !== want.anode_byte) begin
                report("anode_byte", want.anode_byte, got.anode_byte);
            end
            if (got.segment_byte !== want.segment_byte) begin
                report("segment_byte", want.segment_byte, got.segment_byte);
            end
            if (got.hours_now !== want.hours_now) begin
                report("hours_now", 8'(want.hours_now), 8'(got.hours_now));
            end
            if (got.minutes_now !== want.minutes_now) begin
                report("minutes_now", 8'(want.minutes_now), 8'(got.minutes_now));
            end
            if (got.seconds_now !== want.seconds_now) begin
                report("seconds_now", 8'(want.seconds_now), 8'(got.seconds_now));
            end
            if (got.time_is_set !== want.time_is_set) begin
                report("time_is_set", 8'(want.time_is_set), 8'(got.time_is_set));
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [9:0]   cfg_data  = '0;
    logic         s_valid   = 1'b0;
    logic         s_ready;
    in_item_t     s_item    = '0;
    logic         m_valid;
    logic         m_ready   = 1'b0;
    result_item_t m_item;

    clock_tracker board = new();
    bit           calm = 1'b0;
    int           items_sent = 0;
    int           ticks_sent = 0;

    digital_clock_with_set_and_display_scan dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(in_item_t it);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        board.take_request(it);
        items_sent++;
        if (it.command == CMD_TICK) begin
            ticks_sent++;
        end
    endtask

    task automatic send_tick(logic hour_level, logic minute_level);
        in_item_t it;
        it.command           = CMD_TICK;
        it.raw_hour_switch   = hour_level;
        it.raw_minute_switch = minute_level;
        send_item(it);
    endtask

    task automatic send_scan();
        in_item_t it;
        it.command           = CMD_SCAN;
        it.raw_hour_switch   = 1'($urandom_range(0, 1));
        it.raw_minute_switch = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic write_limit(logic [9:0] v);
        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        board.set_limit(v);
        cfg_valid <= 1'b0;
    endtask

    // A press is one or more released samples followed by seven held ones.
    task automatic issue_burst(int scan_pct, int press_pct);
        int       pick;
        logic [1:0] which;
        pick  = $urandom_range(0, 99);
        which = 2'($urandom_range(1, 3));
        if (pick < scan_pct) begin
            repeat ($urandom_range(1, 4)) send_scan();
        end else if (pick < scan_pct + press_pct) begin
            repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'b1);
            repeat (7) begin
                send_tick(~which[0], ~which[1]);
                if ($urandom_range(0, 9) == 0) begin
                    send_scan();
                end
            end
        end else if (pick < scan_pct + press_pct + 15) begin
            send_tick(1'b1, 1'b1);
            repeat ($urandom_range(1, 6)) send_tick(~which[0], ~which[1]);
            send_tick(1'b1, 1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) begin
                send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic run_phase(logic [9:0] lim, int item_goal, int tick_goal,
                             int scan_pct, int press_pct);
        int items_from;
        int ticks_from;
        write_limit(lim);
        items_from = items_sent;
        ticks_from = ticks_sent;
        while (items_sent - items_from < item_goal || ticks_sent - ticks_from < tick_goal) begin
            issue_burst(scan_pct, press_pct);
        end
    endtask

    initial begin
        int idle_left;
        bit held;
        idle_left = 0;
        held      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.compare_result(m_item);
            end
            if (!held && board.checked >= 300) begin
                held      = 1'b1;
                idle_left = 90;
            end else if (idle_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(1, 12);
            end
            if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Blank digits while unset on odd seconds, then both buttons pressed together.
        write_limit(10'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        repeat (4) send_scan();
        repeat (7) send_tick(1'b0, 1'b0);
        repeat (4) send_scan();
        send_tick(1'b1, 1'b0);
        repeat (2) send_scan();

        run_phase(10'd0, 130, 0, 20, 15);
        run_phase(10'd1, 100, 0, 25, 45);
        run_phase(10'd1023, 0, 1028, 8, 45);
        run_phase(10'd511, 0, 530, 8, 45);
        calm = 1'b1;
        run_phase(10'($urandom_range(2, 12)), 120, 0, 25, 45);

        s_valid <= 1'b0;
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
